FILE: design/tw_odo_pkg.sv
// Package for the three-wheel tracking odometry block.
// Holds the payload structs, register indexes and the CORDIC arctangent table.
// No dependencies.
package tw_odo_pkg;

   typedef struct packed {
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
      logic signed [31:0] back_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        heading;
   } rsp_type;

   localparam logic [1:0] REG_DIST_PER_COUNT = 2'd0;
   localparam logic [1:0] REG_WHEEL_BASE     = 2'd1;
   localparam logic [1:0] REG_BACK_OFFSET    = 2'd2;

   localparam logic signed [33:0] BAM_PER_RAD = 34'sd683565276;
   localparam logic signed [33:0] INV_GAIN    = 34'sh9B74EDA8;
   localparam logic signed [33:0] QUARTER     = 34'sh40000000;

   // Arctangent of 2^-i as a binary angle, one turn equals 2^32.
   function automatic logic [31:0] atan_bam(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001; default: r = 32'h00000000;
         endcase
         return r;
      end
   endfunction

endpackage

FILE: design/three_wheel_odometry.sv
// Three-wheel tracking odometry: a sequencer around one shared multiplier, two fixed
// product multipliers, one restoring divider and one CORDIC add/shift stage. Uses tw_odo_pkg.
// From request transfer to rsp_valid: setup (S_DL, S_DR, S_DB, S_PROD), the heading
// division, the sideways division, the gain states S_GAINX and S_GAINY, then CORDIC.
// A new request is taken only in S_IDLE, once the last item is through; a result still
// waiting when the next item ends holds the last CORDIC rotation. Synchronous active-high reset.
module three_wheel_odometry #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tw_odo_pkg::req_type    req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tw_odo_pkg::rsp_type    rsp_data,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [23:0]            csr_wdata
);

   localparam int IW = $clog2(CORDIC_STEPS + 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DL    = 10'b0000000010,
      S_DR    = 10'b0000000100,
      S_DB    = 10'b0000001000,
      S_PROD  = 10'b0000010000,
      S_DIV1  = 10'b0000100000,
      S_DIV2  = 10'b0001000000,
      S_GAINX = 10'b0010000000,
      S_GAINY = 10'b0100000000,
      S_CORD  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [23:0] dpc_ff;
   logic [15:0] wb_ff;
   logic signed [15:0] bo_ff;
   logic [31:0] prev_l_ff, prev_r_ff, prev_b_ff;
   logic [31:0] acc_x_ff, acc_y_ff, acc_h_ff;
   logic [31:0] cur_l_ff, cur_r_ff, cur_b_ff;
   logic signed [31:0] dl_ff, dr_ff, db_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic [IW-1:0] it_ff;
   logic rsp_valid_ff;
   tw_odo_pkg::rsp_type rsp_ff;

   // Divider: magnitude, divisor, quotient, remainder, sign, bit counter.
   logic [62:0] dv_num_ff;
   logic [23:0] dv_den_ff;
   logic [62:0] dv_q_ff;
   logic [24:0] dv_rem_ff;
   logic dv_neg_ff;
   logic [5:0] dv_cnt_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Shared multiplier: 34 x 34 signed, picks operands by state.
   logic signed [33:0] ma, mb;
   logic signed [67:0] mp;
   logic [31:0] dsel;
   logic signed [31:0] dmul;
   logic signed [32:0] diff;
   logic [15:0] wb_eff;

   assign wb_eff = (wb_ff == 16'd0) ? 16'd1 : wb_ff;
   assign diff = 33'(dr_ff) - 33'(dl_ff);

   always_comb begin
      unique case (state_ff)
         S_DL:    dsel = cur_l_ff - prev_l_ff;
         S_DR:    dsel = cur_r_ff - prev_r_ff;
         default: dsel = cur_b_ff - prev_b_ff;
      endcase
      dmul = $signed(dsel);
      ma = 34'(dmul);
      mb = $signed({10'd0, dpc_ff});
      unique case (state_ff)
         S_GAINX: begin
            ma = x_ff;
            mb = tw_odo_pkg::INV_GAIN;
         end
         S_GAINY: begin
            ma = y_ff;
            mb = tw_odo_pkg::INV_GAIN;
         end
         default: ;
      endcase
      mp = ma * mb;
   end

   // Wheel distance: floor shift by 8, then saturate.
   logic signed [59:0] wsh;
   logic signed [31:0] wsat;
   always_comb begin
      wsh = 60'(mp >>> 8);
      if (wsh > 60'sd2147483647)        wsat = 32'sh7FFFFFFF;
      else if (wsh < -60'sd2147483648)  wsat = 32'sh80000000;
      else                              wsat = wsh[31:0];
   end

   // Restoring divider step, one quotient bit per cycle.
   logic [24:0] rem_sh;
   logic rem_ge;
   assign rem_sh = {dv_rem_ff[23:0], dv_num_ff[62]};
   assign rem_ge = rem_sh >= {1'b0, dv_den_ff};

   logic signed [63:0] q_signed;
   assign q_signed = dv_neg_ff ? -$signed({1'b0, dv_q_ff}) : $signed({1'b0, dv_q_ff});

   // Second dividend: diff * back_offset, magnitude.
   logic signed [49:0] side_prod;
   logic [49:0] side_mag;
   assign side_prod = 50'(diff) * 50'(bo_ff);
   assign side_mag  = side_prod[49] ? 50'(-side_prod) : side_prod;

   // Sideways result and saturation, valid once the second quotient is complete.
   logic signed [64:0] dy_full;
   logic signed [31:0] dy_sat;
   always_comb begin
      dy_full = 65'(db_ff) - 65'(q_signed);
      if (dy_full > 65'sd2147483647)       dy_sat = 32'sh7FFFFFFF;
      else if (dy_full < -65'sd2147483648) dy_sat = 32'sh80000000;
      else                                 dy_sat = dy_full[31:0];
   end

   // First dividend: diff * BAM_PER_RAD, magnitude.
   logic signed [66:0] th_prod;
   logic [62:0] th_mag;
   assign th_prod = 67'(diff) * 67'(tw_odo_pkg::BAM_PER_RAD);
   assign th_mag  = th_prod[66] ? 63'(-th_prod) : 63'(th_prod);

   // CORDIC step.
   logic signed [33:0] xs, ys;
   logic [31:0] at;
   logic signed [33:0] x_nx, y_nx, z_nx;
   assign xs = x_ff >>> it_ff;
   assign ys = y_ff >>> it_ff;
   assign at = tw_odo_pkg::atan_bam(5'(it_ff));
   assign x_nx = z_ff[33] ? x_ff + ys : x_ff - ys;
   assign y_nx = z_ff[33] ? y_ff - xs : y_ff + xs;
   assign z_nx = z_ff[33] ? z_ff + $signed({2'b00, at}) : z_ff - $signed({2'b00, at});

   // New heading from the low word of the finished heading quotient.
   logic [31:0] q_last;
   logic [31:0] h_new;
   assign q_last = {dv_q_ff[30:0], rem_ge};
   assign h_new  = acc_h_ff + (dv_neg_ff ? -q_last : q_last);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_DL;
         S_DL:    state_in = S_DR;
         S_DR:    state_in = S_DB;
         S_DB:    state_in = S_PROD;
         S_PROD:  state_in = S_DIV1;
         S_DIV1:  if (dv_cnt_ff == 6'd0) state_in = S_DIV2;
         S_DIV2:  if (dv_cnt_ff == 6'd0) state_in = S_GAINX;
         S_GAINX: state_in = S_GAINY;
         S_GAINY: state_in = S_CORD;
         S_CORD:  if (it_ff == IW'(CORDIC_STEPS - 1) && (!rsp_valid_ff || rsp_ready))
                     state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dpc_ff       <= 24'd439223;
         wb_ff        <= 16'd3072;
         bo_ff        <= 16'sd0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         prev_b_ff    <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_h_ff     <= '0;
      end else begin
         state_ff <= state_in;

         // The result register fills on the last rotation and empties on a transfer.
         if (state_ff == S_CORD && state_in == S_IDLE) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         // Configuration writes.
         if (csr_write) begin
            unique case (csr_index)
               tw_odo_pkg::REG_DIST_PER_COUNT: dpc_ff <= csr_wdata;
               tw_odo_pkg::REG_WHEEL_BASE:     wb_ff  <= csr_wdata[15:0];
               tw_odo_pkg::REG_BACK_OFFSET:    bo_ff  <= $signed(csr_wdata[15:0]);
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               cur_l_ff <= req_data.left_count;
               cur_r_ff <= req_data.right_count;
               cur_b_ff <= req_data.back_count;
            end
            S_DL: begin
               dl_ff     <= wsat;
               prev_l_ff <= cur_l_ff;
            end
            S_DR: begin
               dr_ff     <= wsat;
               prev_r_ff <= cur_r_ff;
            end
            S_DB: begin
               db_ff     <= wsat;
               prev_b_ff <= cur_b_ff;
               x_ff      <= 34'((33'(dl_ff) + 33'(dr_ff)) >>> 1);
            end
            S_PROD: begin
               // Heading change divides by wheel_base * 256.
               dv_num_ff <= th_mag;
               dv_den_ff <= {wb_eff, 8'd0};
               dv_neg_ff <= th_prod[66];
               dv_q_ff   <= '0;
               dv_rem_ff <= '0;
               dv_cnt_ff <= 6'd62;
            end
            S_DIV1, S_DIV2: begin
               if (state_ff == S_DIV1 && dv_cnt_ff == 6'd0) begin
                  // End of the heading division: store the heading, start the sideways one.
                  dv_num_ff <= {side_mag, 13'd0};
                  dv_den_ff <= {8'd0, wb_eff};
                  dv_neg_ff <= side_prod[49];
                  dv_q_ff   <= '0;
                  dv_rem_ff <= '0;
                  dv_cnt_ff <= 6'd49;
                  acc_h_ff  <= h_new;
                  z_ff      <= 34'($signed(h_new));
               end else begin
                  dv_rem_ff <= rem_ge ? rem_sh - {1'b0, dv_den_ff} : rem_sh;
                  dv_q_ff   <= {dv_q_ff[61:0], rem_ge};
                  dv_num_ff <= {dv_num_ff[61:0], 1'b0};
                  dv_cnt_ff <= dv_cnt_ff - 6'd1;
               end
            end
            S_GAINX: begin
               x_ff <= 34'(mp >>> 32);
               y_ff <= 34'(dy_sat);
            end
            S_GAINY: begin
               // Quarter-turn pre-rotation then start CORDIC.
               if (z_ff > tw_odo_pkg::QUARTER) begin
                  x_ff <= -34'(mp >>> 32);
                  y_ff <= x_ff;
                  z_ff <= z_ff - tw_odo_pkg::QUARTER;
               end else if (z_ff < -tw_odo_pkg::QUARTER) begin
                  x_ff <= 34'(mp >>> 32);
                  y_ff <= -x_ff;
                  z_ff <= z_ff + tw_odo_pkg::QUARTER;
               end else begin
                  y_ff <= 34'(mp >>> 32);
               end
               it_ff <= '0;
            end
            S_CORD: begin
               // The last rotation goes straight into the accumulators and the result.
               if (it_ff != IW'(CORDIC_STEPS - 1)) begin
                  x_ff  <= x_nx;
                  y_ff  <= y_nx;
                  z_ff  <= z_nx;
                  it_ff <= it_ff + IW'(1);
               end else if (state_in == S_IDLE) begin
                  acc_x_ff       <= acc_x_ff + 32'(x_nx);
                  acc_y_ff       <= acc_y_ff + 32'(y_nx);
                  rsp_ff.pos_x   <= $signed(acc_x_ff + 32'(x_nx));
                  rsp_ff.pos_y   <= $signed(acc_y_ff + 32'(y_nx));
                  rsp_ff.heading <= acc_h_ff;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

FILE: design/tw_odo_checker.sv
// Port-level checker for three_wheel_odometry, attached by bind.
// Uses tw_odo_pkg for the payload types.
module tw_odo_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input tw_odo_pkg::rsp_type rsp_data
);

   // A request transfer makes the block busy on the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after transfer");

   // A waiting result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No result right after a request transfer taken while no result is waiting.
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result too early");

endmodule

bind three_wheel_odometry tw_odo_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));

FILE: tb/tb_top.sv
// Self-checking testbench for the three-wheel tracking odometry block.
// Drives encoder readings over valid/ready, predicts pose with its own CORDIC model.
// Depends on tw_odo_pkg and three_wheel_odometry.
`timescale 1ns / 1ps

module tb_top;

   localparam int STEPS = 24;
   localparam int LATENCY = 120 + STEPS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 400;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   tw_odo_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   tw_odo_pkg::rsp_type rsp_data;
   logic                csr_write;
   logic [1:0]          csr_index;
   logic [23:0]         csr_wdata;

   // Predictor state and configuration.
   logic [23:0]        dist_scale;
   logic [15:0]        base_q88;
   logic signed [15:0] offset_q88;
   logic [31:0]        last_left, last_right, last_back;
   logic [31:0]        pose_x, pose_y, pose_heading;

   tw_odo_pkg::req_type pending_reads[$];
   tw_odo_pkg::rsp_type expected_poses[$];
   tw_odo_pkg::req_type last_queued;
   int      errors;
   int      mismatches;
   int      cycles;
   bit      stim_done;
   bit      req_taken;
   int      burst_left;
   int      gap_left;

   three_wheel_odometry #(.CORDIC_STEPS(STEPS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Floor shift of a signed 64-bit value.
   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Signed quotient truncated toward zero.
   function automatic longint quot_tz(input longint a, input longint b);
      longint m;
      m = (a < 0) ? -a : a;
      m = m / b;
      return (a < 0) ? -m : m;
   endfunction

   function automatic longint wheel_inches(input logic [31:0] cur, input logic [31:0] prev);
      logic [31:0] d;
      d = cur - prev;
      return clamp32(floor_shift(longint'($signed(d)) * longint'(dist_scale), 8));
   endfunction

   // Advance the pose model by one set of readings.
   function automatic tw_odo_pkg::rsp_type advance_pose(input tw_odo_pkg::req_type r);
      longint dl, dr, db, diff, wb, dx, dy, x, y, z, t, xs, ys;
      logic [31:0] dtheta;
      tw_odo_pkg::rsp_type p;
      dl = wheel_inches(r.left_count, last_left);
      dr = wheel_inches(r.right_count, last_right);
      db = wheel_inches(r.back_count, last_back);
      last_left = r.left_count;
      last_right = r.right_count;
      last_back = r.back_count;
      wb = (base_q88 == 16'd0) ? 64'sd1 : longint'(base_q88);
      diff = dr - dl;
      dtheta = 32'(quot_tz(diff * 64'sd683565276, wb * 256));
      dx = floor_shift(dl + dr, 1);
      dy = clamp32(db - quot_tz(diff * longint'(offset_q88), wb));
      pose_heading = pose_heading + dtheta;
      x = floor_shift(dx * 64'sh9B74EDA8, 32);
      y = floor_shift(dy * 64'sh9B74EDA8, 32);
      z = longint'($signed(pose_heading));
      if (z > 64'sh40000000) begin
         t = x; x = -y; y = t;
         z = z - 64'sh40000000;
      end else if (z < -64'sh40000000) begin
         t = x; x = y; y = -t;
         z = z + 64'sh40000000;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(tw_odo_pkg::atan_bam(5'(i)));
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(tw_odo_pkg::atan_bam(5'(i)));
         end
      end
      pose_x = pose_x + 32'(x);
      pose_y = pose_y + 32'(y);
      p.pos_x = pose_x;
      p.pos_y = pose_y;
      p.heading = pose_heading;
      return p;
   endfunction

   // Register write at the next rising edge; the model follows at once.
   task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         tw_odo_pkg::REG_DIST_PER_COUNT: dist_scale = val;
         tw_odo_pkg::REG_WHEEL_BASE:     base_q88 = val[15:0];
         tw_odo_pkg::REG_BACK_OFFSET:    offset_q88 = val[15:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_reads.size() != 0 || req_valid || expected_poses.size() != 0)
         @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   function automatic tw_odo_pkg::req_type random_read(input bit wide);
      tw_odo_pkg::req_type r;
      if (wide) begin
         r.left_count = $urandom;
         r.right_count = $urandom;
         r.back_count = $urandom;
      end else begin
         r.left_count = last_queued.left_count + 32'($signed($urandom_range(0, 4000)) - 2000);
         r.right_count = last_queued.right_count + 32'($signed($urandom_range(0, 4000)) - 2000);
         r.back_count = last_queued.back_count + 32'($signed($urandom_range(0, 4000)) - 2000);
      end
      return r;
   endfunction

   task automatic queue_read(input tw_odo_pkg::req_type r);
      pending_reads.push_back(r);
      last_queued = r;
   endtask

   // Stimulus sequence.
   initial begin
      tw_odo_pkg::req_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write = 1'b0;
      csr_index = tw_odo_pkg::REG_DIST_PER_COUNT;
      csr_wdata = '0;
      errors = 0; mismatches = 0; stim_done = 0;
      last_queued = '0;
      dist_scale = 24'd439223; base_q88 = 16'd3072; offset_q88 = 16'sd0;
      last_left = 0; last_right = 0; last_back = 0;
      pose_x = 0; pose_y = 0; pose_heading = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset configuration, extremes of the counts and large jumps.
      r = '{32'sd100, 32'sd200, 32'sd50};                 queue_read(r);
      r = '{32'sd100, 32'sd200, 32'sd50};                 queue_read(r);
      r = '{32'h7FFFFFFF, 32'h80000000, 32'h0};           queue_read(r);
      r = '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF};    queue_read(r);
      r = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF};    queue_read(r);
      r = '{32'h0, 32'h0, 32'h0};                         queue_read(r);
      wait_idle();

      // Extremes of the registers, including zero wheel base.
      write_reg(tw_odo_pkg::REG_DIST_PER_COUNT, 24'hFFFFFF);
      write_reg(tw_odo_pkg::REG_WHEEL_BASE, 24'd0);
      write_reg(tw_odo_pkg::REG_BACK_OFFSET, 24'h007FFF);
      r = '{32'sd1000, -32'sd1000, 32'sd5};               queue_read(r);
      r = '{32'h40000000, 32'hC0000000, 32'h12345678};    queue_read(r);
      r = '{32'sd0, 32'sd0, 32'sd0};                      queue_read(r);
      wait_idle();
      write_reg(tw_odo_pkg::REG_DIST_PER_COUNT, 24'd0);
      write_reg(tw_odo_pkg::REG_WHEEL_BASE, 24'h00FFFF);
      write_reg(tw_odo_pkg::REG_BACK_OFFSET, 24'h008000);
      r = '{32'sd77, 32'sd99, -32'sd5};                   queue_read(r);
      r = '{32'hDEADBEEF, 32'h0BADF00D, 32'hCAFEF00D};    queue_read(r);
      wait_idle();
      write_reg(tw_odo_pkg::REG_WHEEL_BASE, 24'd1);
      write_reg(tw_odo_pkg::REG_DIST_PER_COUNT, 24'd1);
      write_reg(tw_odo_pkg::REG_BACK_OFFSET, 24'h00FFFF);
      // A write to the unused index must be ignored.
      write_reg(REG_UNUSED, 24'hABCDEF);
      for (int i = 0; i < 8; i++) queue_read(random_read(1'b1));
      wait_idle();

      // Random phases under several settings.
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(tw_odo_pkg::REG_DIST_PER_COUNT, 24'($urandom));
         write_reg(tw_odo_pkg::REG_WHEEL_BASE,
                   (ph == 3) ? 24'd3072 : 24'($urandom_range(1, 65535)));
         write_reg(tw_odo_pkg::REG_BACK_OFFSET, 24'($urandom_range(0, 65535)));
         for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            queue_read(random_read($urandom_range(0, 9) == 0));
         // The sender holds off until every pose has come back.
         wait_idle();
      end
      stim_done = 1;
   end

   // Driver: bursts of transfers with random gaps, valid held until accepted.
   always @(negedge clock) begin
      if (reset) begin
         burst_left <= 0;
         gap_left <= 0;
      end else if (req_valid && !req_taken) begin
         // Hold the current transfer.
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_reads.size() != 0) begin
         req_data <= pending_reads.pop_front();
         req_valid <= 1'b1;
         if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver stall pattern: long ready stretches mixed with random stalls.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if ((cycles / 2000) % 3 == 0) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // Monitor: predict on each input transfer, check each result transfer.
   always @(posedge clock) begin
      tw_odo_pkg::rsp_type want;
      cycles <= cycles + 1;
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_poses.push_back(advance_pose(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_poses.size() == 0) begin
               errors++;
               if (mismatches < 10) $display("unexpected result transfer %h", rsp_data);
               mismatches++;
            end else begin
               want = expected_poses.pop_front();
               if (want.pos_x !== rsp_data.pos_x || want.pos_y !== rsp_data.pos_y ||
                   want.heading !== rsp_data.heading) begin
                  errors++;
                  if (mismatches < 10)
                     $display("pose mismatch: want x=%h y=%h h=%h got x=%h y=%h h=%h",
                              want.pos_x, want.pos_y, want.heading,
                              rsp_data.pos_x, rsp_data.pos_y, rsp_data.heading);
                  mismatches++;
               end
            end
         end
      end
   end

   // End of run and timeout.
   initial begin
      cycles = 0;
      wait (stim_done);
      repeat (LATENCY) @(posedge clock);
      if (errors == 0 && expected_poses.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

endmodule
